/* design/triangle_edge_rasterizer_defines.svh */
// Assertion macros used by the rasterizer back end
`ifndef TRIANGLE_EDGE_RASTERIZER_DEFINES_SVH
`define TRIANGLE_EDGE_RASTERIZER_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle
`define TER_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define TER_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

/* design/ter_pkg.sv */
package ter_pkg;

  localparam int CoordW = 12;
  localparam int ColorW = 32;
  localparam int CountW = 13;
  localparam int EdgeW  = 27;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic CFG_BG_COLOR   = 1'b0;
  localparam logic CFG_DRAW_COLOR = 1'b1;

  // Classified command passed from the front end to the back end
  typedef struct packed {
    logic [1:0]               op;
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] minx;
    logic signed [CoordW-1:0] maxx;
    logic signed [CoordW-1:0] miny;
    logic signed [CoordW-1:0] maxy;
    logic [5:0]               col;
    logic [5:0]               row;
  } ter_cmd_t;

  function automatic logic signed [CoordW-1:0] min3(
      input logic signed [CoordW-1:0] a, input logic signed [CoordW-1:0] b,
      input logic signed [CoordW-1:0] c);
    logic signed [CoordW-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [CoordW-1:0] max3(
      input logic signed [CoordW-1:0] a, input logic signed [CoordW-1:0] b,
      input logic signed [CoordW-1:0] c);
    logic signed [CoordW-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // Edge function (b-a) x (c-a)
  function automatic logic signed [EdgeW-1:0] edge_fn(
      input logic signed [CoordW-1:0] ax, input logic signed [CoordW-1:0] ay,
      input logic signed [CoordW-1:0] bx, input logic signed [CoordW-1:0] by,
      input logic signed [CoordW-1:0] cx, input logic signed [CoordW-1:0] cy);
    logic signed [CoordW:0] dx1;
    logic signed [CoordW:0] dy1;
    logic signed [CoordW:0] dx2;
    logic signed [CoordW:0] dy2;
    logic signed [EdgeW-2:0] p1;
    logic signed [EdgeW-2:0] p2;
    dx1 = {bx[CoordW-1], bx} - {ax[CoordW-1], ax};
    dy1 = {by[CoordW-1], by} - {ay[CoordW-1], ay};
    dx2 = {cx[CoordW-1], cx} - {ax[CoordW-1], ax};
    dy2 = {cy[CoordW-1], cy} - {ay[CoordW-1], ay};
    p1 = dx1 * dy2;
    p2 = dy1 * dx2;
    return EdgeW'(p1) - EdgeW'(p2);
  endfunction

endpackage

/* design/ter_front.sv */
// Front end: classify command, compute clamped box and vertex order
module ter_front import ter_pkg::*; #(
  parameter int WIDTH  = 64,
  parameter int HEIGHT = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               op,
  input  logic signed [CoordW-1:0] x0,
  input  logic signed [CoordW-1:0] y0,
  input  logic signed [CoordW-1:0] x1,
  input  logic signed [CoordW-1:0] y1,
  input  logic signed [CoordW-1:0] x2,
  input  logic signed [CoordW-1:0] y2,
  input  logic [5:0]               pixel_col,
  input  logic [5:0]               pixel_row,
  output logic                     cmd_valid,
  input  logic                     cmd_ready,
  output ter_cmd_t                 cmd
);

  localparam logic signed [CoordW-1:0] XMax = CoordW'(WIDTH - 1);
  localparam logic signed [CoordW-1:0] YMax = CoordW'(HEIGHT - 1);

  logic                     stage_valid;
  logic [1:0]               s_op;
  logic signed [CoordW-1:0] s_x0, s_y0, s_x1, s_y1, s_x2, s_y2;
  logic [5:0]               s_col, s_row;
  logic signed [EdgeW-1:0]  orient;
  logic signed [CoordW-1:0] lo_x, hi_x, lo_y, hi_y;
  logic                     swap;
  ter_cmd_t                 cmd_next;
  logic                     stage_ready;

  // Two-entry queue between front and back
  ter_cmd_t q_mem [2];
  logic     q_wr, q_rd;
  logic [1:0] q_cnt;

  assign stage_ready = !stage_valid || (q_cnt != 2'd2);
  assign in_ready    = stage_ready;

  // Capture the incoming beat
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (stage_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_op <= op; s_x0 <= x0; s_y0 <= y0; s_x1 <= x1; s_y1 <= y1;
      s_x2 <= x2; s_y2 <= y2; s_col <= pixel_col; s_row <= pixel_row;
    end
  end

  // Classify: clamp box and order vertices counter-clockwise
  always_comb begin
    orient = edge_fn(s_x0, s_y0, s_x1, s_y1, s_x2, s_y2);
    swap   = orient < 0;
    lo_x   = min3(s_x0, s_x1, s_x2);
    hi_x   = max3(s_x0, s_x1, s_x2);
    lo_y   = min3(s_y0, s_y1, s_y2);
    hi_y   = max3(s_y0, s_y1, s_y2);
    cmd_next.op   = s_op;
    cmd_next.ax   = s_x0;
    cmd_next.ay   = s_y0;
    cmd_next.bx   = swap ? s_x2 : s_x1;
    cmd_next.by   = swap ? s_y2 : s_y1;
    cmd_next.cx   = swap ? s_x1 : s_x2;
    cmd_next.cy   = swap ? s_y1 : s_y2;
    cmd_next.minx = (lo_x < 0) ? '0 : lo_x;
    cmd_next.miny = (lo_y < 0) ? '0 : lo_y;
    cmd_next.maxx = (hi_x > XMax) ? XMax : hi_x;
    cmd_next.maxy = (hi_y > YMax) ? YMax : hi_y;
    cmd_next.col  = s_col;
    cmd_next.row  = s_row;
  end

  assign q_wr = stage_valid && (q_cnt != 2'd2);
  assign q_rd = cmd_valid && cmd_ready;

  logic q_wp, q_rp;

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= '0; q_wp <= 1'b0; q_rp <= 1'b0;
    end else begin
      if (q_wr) q_wp <= ~q_wp;
      if (q_rd) q_rp <= ~q_rp;
      q_cnt <= q_cnt + {1'b0, q_wr} - {1'b0, q_rd};
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr) q_mem[q_wp] <= cmd_next;
  end

  assign cmd_valid = q_cnt != 2'd0;
  assign cmd       = q_mem[q_rp];

endmodule

/* design/ter_back.sv */
// Back end: frame store, scan engine and result register
module ter_back import ter_pkg::*; #(
  parameter int WIDTH  = 64,
  parameter int HEIGHT = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  ter_cmd_t          cmd,
  input  logic [ColorW-1:0] bg_color,
  input  logic [ColorW-1:0] draw_color,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ColorW-1:0] read_data,
  output logic [CountW-1:0] pixels_written,
  output logic              busy
);
  `include "triangle_edge_rasterizer_defines.svh"

  localparam int NPix  = WIDTH * HEIGHT;
  localparam int AddrW = $clog2(NPix);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_DRAW  = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_RDATA = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state;
  ter_cmd_t   cur;
  logic [AddrW-1:0] addr;
  logic signed [CoordW-1:0] px, py;
  logic [CountW-1:0] count;
  logic [ColorW-1:0] mem [NPix];
  logic [ColorW-1:0] rd_q;
  logic              we;
  logic [AddrW-1:0]  waddr;
  logic [ColorW-1:0] wdata;
  logic              inside_tri;
  logic [AddrW-1:0]  pix_addr;
  logic              read_ok;
  logic signed [EdgeW-1:0] e0, e1, e2;

  assign cmd_ready = (state == ST_IDLE);
  assign busy      = (state != ST_IDLE);

  // Coverage test of the current scan pixel
  always_comb begin
    e0 = edge_fn(cur.bx, cur.by, cur.cx, cur.cy, px, py);
    e1 = edge_fn(cur.cx, cur.cy, cur.ax, cur.ay, px, py);
    e2 = edge_fn(cur.ax, cur.ay, cur.bx, cur.by, px, py);
    inside_tri = (e0 >= 0) && (e1 >= 0) && (e2 >= 0);
    pix_addr = AddrW'((HEIGHT - 1 - int'(py)) * WIDTH + int'(px));
    read_ok  = (int'(cur.col) < WIDTH) && (int'(cur.row) < HEIGHT);
  end

  always_comb begin
    we    = 1'b0;
    waddr = addr;
    wdata = bg_color;
    if (state == ST_CLEAR) begin
      we = 1'b1;
    end else if (state == ST_DRAW && inside_tri) begin
      we = 1'b1; waddr = pix_addr; wdata = draw_color;
    end
  end

  // Frame store
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[addr];
  end

  // Sequencer: one pixel per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_DONE) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd; addr <= '0; count <= '0;
            px <= cmd.minx; py <= cmd.miny;
            unique case (cmd.op)
              OP_CLEAR: state <= ST_CLEAR;
              OP_DRAW: begin
                if (cmd.minx < cmd.maxx && cmd.miny < cmd.maxy) state <= ST_DRAW;
                else state <= ST_DONE;
              end
              OP_READ: begin
                addr <= AddrW'(int'(cmd.row) * WIDTH + int'(cmd.col));
                state <= ST_READ;
              end
              OP_NONE: state <= ST_DONE;
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_CLEAR: begin
          addr <= addr + 1'b1;
          if (int'(addr) == NPix - 1) begin
            count <= CountW'(NPix);
            state <= ST_DONE;
          end
        end
        ST_DRAW: begin
          if (inside_tri) count <= count + 1'b1;
          if (px + 1 >= cur.maxx) begin
            px <= cur.minx;
            py <= py + 1'b1;
            if (py + 1 >= cur.maxy) state <= ST_DONE;
          end else begin
            px <= px + 1'b1;
          end
        end
        ST_READ:  state <= ST_RDATA;
        ST_RDATA: state <= ST_DONE;
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            pixels_written <= count;
            read_data      <= (cur.op == OP_READ && read_ok) ? rd_q : '0;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `TER_ASSERT_IMP(a_idle_ready, clk, rst, cmd_ready, state == ST_IDLE, "ready outside idle")
  `TER_ASSERT_NEXT(a_done_out, clk, rst, state == ST_DONE && !out_valid, out_valid, "result lost")
  `TER_ASSERT_IMP(a_we_busy, clk, rst, we, busy, "store write while idle")
endmodule

/* design/ter_cfg.sv */
// Configuration registers
module ter_cfg import ter_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [ColorW-1:0] cfg_data,
  output logic [ColorW-1:0] bg_color,
  output logic [ColorW-1:0] draw_color
);
  assign cfg_ready = 1'b1;

  // Hold register values, update on a write beat
  always_ff @(posedge clk) begin
    if (rst) begin
      bg_color   <= '0;
      draw_color <= '1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BG_COLOR:   bg_color   <= cfg_data;
        CFG_DRAW_COLOR: draw_color <= cfg_data;
        default: ;
      endcase
    end
  end
endmodule

/* design/triangle_edge_rasterizer.sv */
// Each command passes the front-end stage register and queue, then the scan engine:
// clear writes every pixel, draw scans the clamped box, read fetches one entry.
// Throughput: one command at a time in the scan engine, one pixel per cycle;
// the front end and a two-entry queue take the next commands meanwhile.
// Reset: synchronous; clears control state, sets the background color to zero and
// the draw color to all ones; the frame store is undefined until a clear.
module triangle_edge_rasterizer import ter_pkg::*; #(
  parameter int WIDTH  = 64,
  parameter int HEIGHT = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               op,
  input  logic signed [CoordW-1:0] x0,
  input  logic signed [CoordW-1:0] y0,
  input  logic signed [CoordW-1:0] x1,
  input  logic signed [CoordW-1:0] y1,
  input  logic signed [CoordW-1:0] x2,
  input  logic signed [CoordW-1:0] y2,
  input  logic [5:0]               pixel_col,
  input  logic [5:0]               pixel_row,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ColorW-1:0]        read_data,
  output logic [CountW-1:0]        pixels_written,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [0:0]               cfg_index,
  input  logic [ColorW-1:0]        cfg_data
);

  logic              cmd_valid, cmd_ready, busy;
  ter_cmd_t          cmd;
  logic [ColorW-1:0] bg_color, draw_color;

  ter_cfg u_cfg (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .bg_color, .draw_color
  );

  ter_front #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_front (
    .clk, .rst, .in_valid, .in_ready, .op, .x0, .y0, .x1, .y1, .x2, .y2,
    .pixel_col, .pixel_row, .cmd_valid, .cmd_ready, .cmd
  );

  ter_back #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_back (
    .clk, .rst, .cmd_valid, .cmd_ready, .cmd, .bg_color, .draw_color,
    .out_valid, .out_ready, .read_data, .pixels_written, .busy
  );

endmodule

/* test/tb_top.sv */
`default_nettype none

module tb_top;
  import ter_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FbW      = 64;
  localparam int FbH      = 64;
  localparam int FbPix    = FbW * FbH;
  localparam int MaxCycle = 3000000;
  localparam int QuietTail = 30;

  typedef struct {
    logic [1:0]               op;
    logic signed [CoordW-1:0] x0, y0, x1, y1, x2, y2;
    logic [5:0]               col, row;
  } raster_cmd_t;

  typedef struct {
    logic [ColorW-1:0] data;
    logic [CountW-1:0] count;
  } raster_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               op = OP_NONE;
  logic signed [CoordW-1:0] x0 = '0, y0 = '0, x1 = '0, y1 = '0, x2 = '0, y2 = '0;
  logic [5:0]               pixel_col = '0, pixel_row = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [ColorW-1:0]        read_data;
  logic [CountW-1:0]        pixels_written;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [0:0]               cfg_index = CFG_BG_COLOR;
  logic [ColorW-1:0]        cfg_data = '0;

  triangle_edge_rasterizer #(.WIDTH(FbW), .HEIGHT(FbH)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .x0(x0), .y0(y0), .x1(x1), .y1(y1), .x2(x2), .y2(y2),
    .pixel_col(pixel_col), .pixel_row(pixel_row),
    .out_valid(out_valid), .out_ready(out_ready),
    .read_data(read_data), .pixels_written(pixels_written),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Shadow copy of the frame store and color registers
  logic [ColorW-1:0] shadow_fb [FbPix];
  logic [ColorW-1:0] shadow_bg_color   = '0;
  logic [ColorW-1:0] shadow_draw_color = '1;

  raster_cmd_t cmd_queue [$];
  raster_res_t expected_res [$];
  int          errors = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;
  bit          in_fire = 1'b0;
  int          in_gap = 0;
  int          out_gap = 0;

  function automatic longint edge_val(longint ax, longint ay, longint bx, longint by,
                                      longint cx, longint cy);
    return (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
  endfunction

  // Rasterize one triangle into the shadow store, return coverage count
  function automatic int raster_tri(raster_cmd_t c);
    int ax, ay, bx, by, cx, cy, t;
    int minx, maxx, miny, maxy, cnt;
    ax = int'(c.x0); ay = int'(c.y0);
    bx = int'(c.x1); by = int'(c.y1);
    cx = int'(c.x2); cy = int'(c.y2);
    cnt = 0;
    minx = (ax < bx) ? ax : bx; minx = (minx < cx) ? minx : cx;
    maxx = (ax > bx) ? ax : bx; maxx = (maxx > cx) ? maxx : cx;
    miny = (ay < by) ? ay : by; miny = (miny < cy) ? miny : cy;
    maxy = (ay > by) ? ay : by; maxy = (maxy > cy) ? maxy : cy;
    if (minx < 0) minx = 0;
    if (miny < 0) miny = 0;
    if (maxx > FbW - 1) maxx = FbW - 1;
    if (maxy > FbH - 1) maxy = FbH - 1;
    // swap to counter-clockwise order
    if (edge_val(ax, ay, bx, by, cx, cy) < 0) begin
      t = bx; bx = cx; cx = t;
      t = by; by = cy; cy = t;
    end
    for (int py = miny; py < maxy; py++) begin
      for (int px = minx; px < maxx; px++) begin
        if (edge_val(bx, by, cx, cy, px, py) >= 0 &&
            edge_val(cx, cy, ax, ay, px, py) >= 0 &&
            edge_val(ax, ay, bx, by, px, py) >= 0) begin
          shadow_fb[(FbH - 1 - py) * FbW + px] = shadow_draw_color;
          cnt++;
        end
      end
    end
    return cnt;
  endfunction

  function automatic raster_res_t predict_pixel_result(raster_cmd_t c);
    raster_res_t r;
    r.data = '0;
    r.count = '0;
    case (c.op)
      OP_CLEAR: begin
        for (int i = 0; i < FbPix; i++) shadow_fb[i] = shadow_bg_color;
        r.count = CountW'(FbPix);
      end
      OP_DRAW: r.count = CountW'(raster_tri(c));
      OP_READ: r.data = shadow_fb[int'(c.row) * FbW + int'(c.col)];
      default: ;
    endcase
    return r;
  endfunction

  // Accept input beats, check result beats, watch the cycle limit
  always @(posedge clk) begin
    raster_cmd_t c;
    raster_res_t e;
    cycles <= cycles + 1;
    in_fire <= !rst && in_valid && in_ready;
    if (cycles > MaxCycle) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      if (!rst && in_valid && in_ready) begin
        c.op = op; c.x0 = x0; c.y0 = y0; c.x1 = x1; c.y1 = y1;
        c.x2 = x2; c.y2 = y2; c.col = pixel_col; c.row = pixel_row;
        expected_res.push_back(predict_pixel_result(c));
      end
      if (!rst && out_valid && out_ready) begin
        if (expected_res.size() == 0) begin
          $error("unexpected result beat: read_data %h pixels_written %0d",
                 read_data, pixels_written);
          errors++;
        end else begin
          e = expected_res.pop_front();
          if (read_data !== e.data) begin
            $error("read_data expected %h actual %h", e.data, read_data);
            errors++;
          end
          if (pixels_written !== e.count) begin
            $error("pixels_written expected %0d actual %0d", e.count, pixels_written);
            errors++;
          end
        end
      end
    end
  end

  // Drive command beats from the pending queue with random gaps
  always @(negedge clk) begin
    raster_cmd_t c;
    logic nxt_valid;
    nxt_valid = in_valid;
    if (in_fire) nxt_valid = 1'b0;
    if (!rst && !nxt_valid) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (cmd_queue.size() > 0) begin
        c = cmd_queue.pop_front();
        op <= c.op; x0 <= c.x0; y0 <= c.y0; x1 <= c.x1; y1 <= c.y1;
        x2 <= c.x2; y2 <= c.y2; pixel_col <= c.col; pixel_row <= c.row;
        nxt_valid = 1'b1;
        if (!quiet && $urandom_range(3) == 0) in_gap = $urandom_range(4, 1);
      end
    end
    in_valid <= nxt_valid;
  end

  // Stall the result side in short bursts
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(4) == 0) out_gap = $urandom_range(4, 1);
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [ColorW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_BG_COLOR) shadow_bg_color = val;
    else shadow_draw_color = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (cmd_queue.size() > 0 || in_valid || expected_res.size() > 0) @(posedge clk);
    repeat (10) @(negedge clk);
  endtask

  function automatic raster_cmd_t mk_cmd(logic [1:0] o, int ax, int ay, int bx, int by,
                                         int cx, int cy, int col, int row);
    raster_cmd_t c;
    c.op = o;
    c.x0 = CoordW'(ax); c.y0 = CoordW'(ay);
    c.x1 = CoordW'(bx); c.y1 = CoordW'(by);
    c.x2 = CoordW'(cx); c.y2 = CoordW'(cy);
    c.col = 6'(col); c.row = 6'(row);
    return c;
  endfunction

  function automatic logic signed [CoordW-1:0] rnd_coord();
    if ($urandom_range(99) < 85) return CoordW'(int'($urandom_range(83)) - 10);
    return CoordW'($urandom);
  endfunction

  function automatic raster_cmd_t rnd_cmd();
    raster_cmd_t c;
    int r;
    r = $urandom_range(99);
    c.op = (r < 4) ? OP_CLEAR : (r < 44) ? OP_DRAW : (r < 94) ? OP_READ : OP_NONE;
    if (c.op == OP_DRAW) begin
      c.x0 = rnd_coord(); c.y0 = rnd_coord(); c.x1 = rnd_coord();
      c.y1 = rnd_coord(); c.x2 = rnd_coord(); c.y2 = rnd_coord();
    end else begin
      c.x0 = CoordW'($urandom); c.y0 = CoordW'($urandom); c.x1 = CoordW'($urandom);
      c.y1 = CoordW'($urandom); c.x2 = CoordW'($urandom); c.y2 = CoordW'($urandom);
    end
    c.col = 6'($urandom);
    c.row = 6'($urandom);
    return c;
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_reg(CFG_BG_COLOR, 32'h0000_0000);
    write_reg(CFG_DRAW_COLOR, 32'hFFFF_FFFF);

    // Directed: clear first so every later read hits a written entry
    cmd_queue.push_back(mk_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    cmd_queue.push_back(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    cmd_queue.push_back(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 63, 63));
    cmd_queue.push_back(mk_cmd(OP_DRAW, 2, 2, 30, 4, 10, 25, 0, 0));       // ccw
    cmd_queue.push_back(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 12, 63 - 8));
    cmd_queue.push_back(mk_cmd(OP_DRAW, 40, 40, 45, 60, 62, 42, 0, 0));    // cw
    cmd_queue.push_back(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 48, 63 - 45));
    cmd_queue.push_back(mk_cmd(OP_DRAW, 1, 1, 10, 10, 20, 20, 0, 0));      // collinear
    cmd_queue.push_back(mk_cmd(OP_DRAW, 5, 5, 5, 5, 5, 5, 0, 0));          // point
    cmd_queue.push_back(mk_cmd(OP_DRAW, 100, 100, 200, 120, 150, 300, 0, 0)); // off screen
    cmd_queue.push_back(mk_cmd(OP_DRAW, -50, -50, -10, -40, -30, -5, 0, 0));
    cmd_queue.push_back(mk_cmd(OP_NONE, -1, -1, -1, -1, -1, -1, 63, 63));
    cmd_queue.push_back(mk_cmd(OP_DRAW, -2048, -2048, 2047, -2048, 0, 2047, 0, 0));
    cmd_queue.push_back(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 32, 32));
    cmd_queue.push_back(mk_cmd(OP_DRAW, 2047, 2047, -2048, 2047, 2047, -2048, 0, 0));
    cmd_queue.push_back(mk_cmd(OP_DRAW, 0, 0, 63, 0, 0, 63, 0, 0));
    cmd_queue.push_back(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 62));
    cmd_queue.push_back(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 63, 0));
    drain();

    // Second setting: random colors, random mix
    write_reg(CFG_BG_COLOR, $urandom);
    write_reg(CFG_DRAW_COLOR, $urandom);
    cmd_queue.push_back(mk_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 60; i++) cmd_queue.push_back(rnd_cmd());
    drain();

    // Third setting: opposite extremes, quiet tail at the end
    write_reg(CFG_BG_COLOR, 32'hFFFF_FFFF);
    write_reg(CFG_DRAW_COLOR, 32'h0000_0000);
    cmd_queue.push_back(mk_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 60; i++) cmd_queue.push_back(rnd_cmd());
    while (cmd_queue.size() > QuietTail) @(negedge clk);
    quiet = 1'b1;
    drain();
    repeat (20) @(negedge clk);

    if (errors == 0 && expected_res.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+design
design/ter_pkg.sv
design/ter_front.sv
design/ter_back.sv
design/ter_cfg.sv
design/triangle_edge_rasterizer.sv
test/tb_top.sv
